FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/gn3_pkg.sv
// Package: permutation table and width constants for 3D gradient noise.
package gn3_pkg;
   localparam int OUT_W = 18;
   localparam int OUT_FRAC = 16;
   localparam int COORD_W = 32;

   function automatic logic [7:0] perm(input logic [7:0] idx);
      logic [7:0] r;
      case (idx)
         8'd0: r=8'd151; 8'd1: r=8'd160; 8'd2: r=8'd137; 8'd3: r=8'd91;
         8'd4: r=8'd90; 8'd5: r=8'd15; 8'd6: r=8'd131; 8'd7: r=8'd13;
         8'd8: r=8'd201; 8'd9: r=8'd95; 8'd10: r=8'd96; 8'd11: r=8'd53;
         8'd12: r=8'd194; 8'd13: r=8'd233; 8'd14: r=8'd7; 8'd15: r=8'd225;
         8'd16: r=8'd140; 8'd17: r=8'd36; 8'd18: r=8'd103; 8'd19: r=8'd30;
         8'd20: r=8'd69; 8'd21: r=8'd142; 8'd22: r=8'd8; 8'd23: r=8'd99;
         8'd24: r=8'd37; 8'd25: r=8'd240; 8'd26: r=8'd21; 8'd27: r=8'd10;
         8'd28: r=8'd23; 8'd29: r=8'd190; 8'd30: r=8'd6; 8'd31: r=8'd148;
         8'd32: r=8'd247; 8'd33: r=8'd120; 8'd34: r=8'd234; 8'd35: r=8'd75;
         8'd36: r=8'd0; 8'd37: r=8'd26; 8'd38: r=8'd197; 8'd39: r=8'd62;
         8'd40: r=8'd94; 8'd41: r=8'd252; 8'd42: r=8'd219; 8'd43: r=8'd203;
         8'd44: r=8'd117; 8'd45: r=8'd35; 8'd46: r=8'd11; 8'd47: r=8'd32;
         8'd48: r=8'd57; 8'd49: r=8'd177; 8'd50: r=8'd33; 8'd51: r=8'd88;
         8'd52: r=8'd237; 8'd53: r=8'd149; 8'd54: r=8'd56; 8'd55: r=8'd87;
         8'd56: r=8'd174; 8'd57: r=8'd20; 8'd58: r=8'd125; 8'd59: r=8'd136;
         8'd60: r=8'd171; 8'd61: r=8'd168; 8'd62: r=8'd68; 8'd63: r=8'd175;
         8'd64: r=8'd74; 8'd65: r=8'd165; 8'd66: r=8'd71; 8'd67: r=8'd134;
         8'd68: r=8'd139; 8'd69: r=8'd48; 8'd70: r=8'd27; 8'd71: r=8'd166;
         8'd72: r=8'd77; 8'd73: r=8'd146; 8'd74: r=8'd158; 8'd75: r=8'd231;
         8'd76: r=8'd83; 8'd77: r=8'd111; 8'd78: r=8'd229; 8'd79: r=8'd122;
         8'd80: r=8'd60; 8'd81: r=8'd211; 8'd82: r=8'd133; 8'd83: r=8'd230;
         8'd84: r=8'd220; 8'd85: r=8'd105; 8'd86: r=8'd92; 8'd87: r=8'd41;
         8'd88: r=8'd55; 8'd89: r=8'd46; 8'd90: r=8'd245; 8'd91: r=8'd40;
         8'd92: r=8'd244; 8'd93: r=8'd102; 8'd94: r=8'd143; 8'd95: r=8'd54;
         8'd96: r=8'd65; 8'd97: r=8'd25; 8'd98: r=8'd63; 8'd99: r=8'd161;
         8'd100: r=8'd1; 8'd101: r=8'd216; 8'd102: r=8'd80; 8'd103: r=8'd73;
         8'd104: r=8'd209; 8'd105: r=8'd76; 8'd106: r=8'd132; 8'd107: r=8'd187;
         8'd108: r=8'd208; 8'd109: r=8'd89; 8'd110: r=8'd18; 8'd111: r=8'd169;
         8'd112: r=8'd200; 8'd113: r=8'd196; 8'd114: r=8'd135; 8'd115: r=8'd130;
         8'd116: r=8'd116; 8'd117: r=8'd188; 8'd118: r=8'd159; 8'd119: r=8'd86;
         8'd120: r=8'd164; 8'd121: r=8'd100; 8'd122: r=8'd109; 8'd123: r=8'd198;
         8'd124: r=8'd173; 8'd125: r=8'd186; 8'd126: r=8'd3; 8'd127: r=8'd64;
         8'd128: r=8'd52; 8'd129: r=8'd217; 8'd130: r=8'd226; 8'd131: r=8'd250;
         8'd132: r=8'd124; 8'd133: r=8'd123; 8'd134: r=8'd5; 8'd135: r=8'd202;
         8'd136: r=8'd38; 8'd137: r=8'd147; 8'd138: r=8'd118; 8'd139: r=8'd126;
         8'd140: r=8'd255; 8'd141: r=8'd82; 8'd142: r=8'd85; 8'd143: r=8'd212;
         8'd144: r=8'd207; 8'd145: r=8'd206; 8'd146: r=8'd59; 8'd147: r=8'd227;
         8'd148: r=8'd47; 8'd149: r=8'd16; 8'd150: r=8'd58; 8'd151: r=8'd17;
         8'd152: r=8'd182; 8'd153: r=8'd189; 8'd154: r=8'd28; 8'd155: r=8'd42;
         8'd156: r=8'd223; 8'd157: r=8'd183; 8'd158: r=8'd170; 8'd159: r=8'd213;
         8'd160: r=8'd119; 8'd161: r=8'd248; 8'd162: r=8'd152; 8'd163: r=8'd2;
         8'd164: r=8'd44; 8'd165: r=8'd154; 8'd166: r=8'd163; 8'd167: r=8'd70;
         8'd168: r=8'd221; 8'd169: r=8'd153; 8'd170: r=8'd101; 8'd171: r=8'd155;
         8'd172: r=8'd167; 8'd173: r=8'd43; 8'd174: r=8'd172; 8'd175: r=8'd9;
         8'd176: r=8'd129; 8'd177: r=8'd22; 8'd178: r=8'd39; 8'd179: r=8'd253;
         8'd180: r=8'd19; 8'd181: r=8'd98; 8'd182: r=8'd108; 8'd183: r=8'd110;
         8'd184: r=8'd79; 8'd185: r=8'd113; 8'd186: r=8'd224; 8'd187: r=8'd232;
         8'd188: r=8'd178; 8'd189: r=8'd185; 8'd190: r=8'd112; 8'd191: r=8'd104;
         8'd192: r=8'd218; 8'd193: r=8'd246; 8'd194: r=8'd97; 8'd195: r=8'd228;
         8'd196: r=8'd251; 8'd197: r=8'd34; 8'd198: r=8'd242; 8'd199: r=8'd193;
         8'd200: r=8'd238; 8'd201: r=8'd210; 8'd202: r=8'd144; 8'd203: r=8'd12;
         8'd204: r=8'd191; 8'd205: r=8'd179; 8'd206: r=8'd162; 8'd207: r=8'd241;
         8'd208: r=8'd81; 8'd209: r=8'd51; 8'd210: r=8'd145; 8'd211: r=8'd235;
         8'd212: r=8'd249; 8'd213: r=8'd14; 8'd214: r=8'd239; 8'd215: r=8'd107;
         8'd216: r=8'd49; 8'd217: r=8'd192; 8'd218: r=8'd214; 8'd219: r=8'd31;
         8'd220: r=8'd181; 8'd221: r=8'd199; 8'd222: r=8'd106; 8'd223: r=8'd157;
         8'd224: r=8'd184; 8'd225: r=8'd84; 8'd226: r=8'd204; 8'd227: r=8'd176;
         8'd228: r=8'd115; 8'd229: r=8'd121; 8'd230: r=8'd50; 8'd231: r=8'd45;
         8'd232: r=8'd127; 8'd233: r=8'd4; 8'd234: r=8'd150; 8'd235: r=8'd254;
         8'd236: r=8'd138; 8'd237: r=8'd236; 8'd238: r=8'd205; 8'd239: r=8'd93;
         8'd240: r=8'd222; 8'd241: r=8'd114; 8'd242: r=8'd67; 8'd243: r=8'd29;
         8'd244: r=8'd24; 8'd245: r=8'd72; 8'd246: r=8'd243; 8'd247: r=8'd141;
         8'd248: r=8'd128; 8'd249: r=8'd195; 8'd250: r=8'd78; 8'd251: r=8'd66;
         8'd252: r=8'd215; 8'd253: r=8'd61; 8'd254: r=8'd156; default: r=8'd180;
      endcase
      return r;
   endfunction
endpackage

FILE: rtl/gn3_front.sv
// Front end: cell hashing for the four x/y corners and offset extraction, two stages.
module gn3_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [31:0]             in_x,
   input  logic [31:0]             in_y,
   input  logic [31:0]             in_z,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [8*4-1:0]          out_hash,
   output logic [3*FRAC_BITS-1:0]  out_frac
);
   import gn3_pkg::*;

   logic                 v1_ff, v2_ff;
   logic [7:0]           a_ff, b_ff, cz_ff;
   logic [3*FRAC_BITS-1:0] f1_ff, f2_ff;
   logic [31:0]          h_ff;
   logic                 adv;
   logic [7:0]           cx, cy, aa, ab, ba, bb;

   assign adv = !v2_ff || out_ready;
   assign in_ready = adv;
   assign cx = in_x[FRAC_BITS +: 8];
   assign cy = in_y[FRAC_BITS +: 8];
   assign aa = perm(a_ff) + cz_ff;
   assign ab = perm(a_ff + 8'd1) + cz_ff;
   assign ba = perm(b_ff) + cz_ff;
   assign bb = perm(b_ff + 8'd1) + cz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         a_ff  <= perm(cx) + cy;
         b_ff  <= perm(cx + 8'd1) + cy;
         cz_ff <= in_z[FRAC_BITS +: 8];
         f1_ff <= {in_z[FRAC_BITS-1:0], in_y[FRAC_BITS-1:0], in_x[FRAC_BITS-1:0]};
         f2_ff <= f1_ff;
         h_ff  <= {bb, ba, ab, aa};
      end
   end

   assign out_valid = v2_ff;
   assign out_hash = h_ff;
   assign out_frac = f2_ff;
endmodule

FILE: rtl/gn3_fifo.sv
// Small two-entry queue between front end and back end.
module gn3_fifo #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         wr, rd;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= in_data;
   end
endmodule

FILE: rtl/gn3_back.sv
// Back end: fade curves, gradients, trilinear interpolation and output scaling.
module gn3_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [31:0]             in_hash,
   input  logic [3*FRAC_BITS-1:0]  in_frac,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [17:0]      out_value
);
   import gn3_pkg::*;

   localparam int F = FRAC_BITS;
   localparam int NS = 11;
   localparam int GW = F + 3;
   localparam int VW = F + 5;
   localparam int PW = 2*F + 5;
   localparam int SW = (F > OUT_FRAC) ? VW + 2 : OUT_W + 5;
   localparam logic [PW-1:0] ONE_P = PW'(1) << F;
   localparam logic [PW-1:0] TEN_ONE2 = PW'(10) << (2*F);

   logic [NS-1:0] v_ff;
   logic adv;
   assign adv = !v_ff[NS-1] || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], in_valid};
   end

   function automatic logic signed [GW-1:0] grad(
      input logic [3:0] h, input logic signed [GW-1:0] x,
      input logic signed [GW-1:0] y, input logic signed [GW-1:0] z);
      logic signed [GW-1:0] u, v;
      u = (h < 4'd8) ? x : y;
      v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic logic signed [VW-1:0] lerp_fin(
      input logic signed [VW-1:0] a, input logic signed [VW+F+1:0] p);
      logic signed [VW+F+1:0] s;
      s = p + ((VW+F+2)'(1) <<< (F-1));
      return a + VW'(s >>> F);
   endfunction

   // stage 1: f^2
   logic [F-1:0]   f_s1 [3];
   logic [2*F-1:0] sq_s1 [3];
   logic [3:0][7:0] h_s1;
   // stage 2: p1, f2
   logic [F-1:0] f_s2 [3];
   logic [F+3:0] p1_s2 [3];
   logic [F-1:0] f2_s2 [3];
   logic [3:0][7:0] h_s2;
   // stage 3: f3
   logic [F-1:0] f_s3 [3];
   logic [F+3:0] p1_s3 [3];
   logic [F-1:0] f3_s3 [3];
   logic [3:0][7:0] h_s3;
   // stage 4: fade, corner hashes
   logic [F-1:0] f_s4 [3];
   logic [F:0]   fd_s4 [3];
   logic [7:0]   ch_s4 [8];
   // stage 5: gradients
   logic [F:0]   fd_s5 [3];
   logic signed [VW-1:0] g_s5 [8];
   // x lerp: product then finish
   logic [F:0]   fd_s6 [3];
   logic signed [VW-1:0] a_s6 [4];
   logic signed [VW+F+1:0] p_s6 [4];
   logic [F:0]   fd_s7 [3];
   logic signed [VW-1:0] l_s7 [4];
   logic [F:0]   fd_s8;
   logic signed [VW-1:0] a_s8 [2];
   logic signed [VW+F+1:0] p_s8 [2];
   logic [F:0]   fd_s9;
   logic signed [VW-1:0] l_s9 [2];
   logic signed [VW-1:0] a_s10;
   logic signed [VW+F+1:0] p_s10;
   logic signed [17:0] r_s11;
   logic [3:0][7:0] hin;
   logic signed [VW-1:0] nfin;
   logic signed [SW-1:0] sc;
   logic signed [GW-1:0] gx0, gx1, gy0, gy1, gz0, gz1;

   assign hin = in_hash;
   assign nfin = lerp_fin(a_s10, p_s10);

   always_comb begin
      if (F > OUT_FRAC)
         sc = (SW'(nfin) + (SW'(1) <<< (F-OUT_FRAC-1))) >>> (F-OUT_FRAC);
      else
         sc = SW'(nfin) <<< (OUT_FRAC-F);
   end

   assign gx0 = GW'(f_s4[0]);
   assign gy0 = GW'(f_s4[1]);
   assign gz0 = GW'(f_s4[2]);
   assign gx1 = GW'(f_s4[0]) - (GW'(1) <<< F);
   assign gy1 = GW'(f_s4[1]) - (GW'(1) <<< F);
   assign gz1 = GW'(f_s4[2]) - (GW'(1) <<< F);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            f_s1[i]  <= in_frac[i*F +: F];
            sq_s1[i] <= in_frac[i*F +: F] * in_frac[i*F +: F];
            f_s2[i]  <= f_s1[i];
            p1_s2[i] <= (F+4)'((TEN_ONE2 + PW'(sq_s1[i]) * PW'(6)
                        - PW'(f_s1[i]) * PW'(15) * ONE_P) >> F);
            f2_s2[i] <= F'(sq_s1[i] >> F);
            f_s3[i]  <= f_s2[i];
            p1_s3[i] <= p1_s2[i];
            f3_s3[i] <= F'(((2*F)'(f2_s2[i]) * (2*F)'(f_s2[i])) >> F);
            f_s4[i]  <= f_s3[i];
            fd_s4[i] <= (F+1)'(((PW'(f3_s3[i]) * PW'(p1_s3[i])) + (ONE_P >> 1)) >> F);
            fd_s5[i] <= fd_s4[i];
            fd_s6[i] <= fd_s5[i];
            fd_s7[i] <= fd_s6[i];
         end
         h_s1 <= hin;
         h_s2 <= h_s1;
         h_s3 <= h_s2;
         // corner order: aa ba ab bb, then each +1
         ch_s4[0] <= perm(h_s3[0]);
         ch_s4[1] <= perm(h_s3[2]);
         ch_s4[2] <= perm(h_s3[1]);
         ch_s4[3] <= perm(h_s3[3]);
         ch_s4[4] <= perm(h_s3[0] + 8'd1);
         ch_s4[5] <= perm(h_s3[2] + 8'd1);
         ch_s4[6] <= perm(h_s3[1] + 8'd1);
         ch_s4[7] <= perm(h_s3[3] + 8'd1);
         g_s5[0] <= VW'(grad(ch_s4[0][3:0], gx0, gy0, gz0));
         g_s5[1] <= VW'(grad(ch_s4[1][3:0], gx1, gy0, gz0));
         g_s5[2] <= VW'(grad(ch_s4[2][3:0], gx0, gy1, gz0));
         g_s5[3] <= VW'(grad(ch_s4[3][3:0], gx1, gy1, gz0));
         g_s5[4] <= VW'(grad(ch_s4[4][3:0], gx0, gy0, gz1));
         g_s5[5] <= VW'(grad(ch_s4[5][3:0], gx1, gy0, gz1));
         g_s5[6] <= VW'(grad(ch_s4[6][3:0], gx0, gy1, gz1));
         g_s5[7] <= VW'(grad(ch_s4[7][3:0], gx1, gy1, gz1));
         for (int j = 0; j < 4; j++) begin
            a_s6[j] <= g_s5[2*j];
            p_s6[j] <= (VW+F+2)'(g_s5[2*j+1] - g_s5[2*j]) *
                       $signed({1'b0, fd_s5[0]});
            l_s7[j] <= lerp_fin(a_s6[j], p_s6[j]);
         end
         for (int k = 0; k < 2; k++) begin
            a_s8[k] <= l_s7[2*k];
            p_s8[k] <= (VW+F+2)'(l_s7[2*k+1] - l_s7[2*k]) *
                       $signed({1'b0, fd_s7[1]});
            l_s9[k] <= lerp_fin(a_s8[k], p_s8[k]);
         end
         fd_s8 <= fd_s7[2];
         fd_s9 <= fd_s8;
         a_s10 <= l_s9[0];
         p_s10 <= (VW+F+2)'(l_s9[1] - l_s9[0]) * $signed({1'b0, fd_s9});
         if (sc > SW'(131071)) r_s11 <= 18'sd131071;
         else if (sc < -SW'(131072)) r_s11 <= -18'sd131072;
         else r_s11 <= 18'(sc);
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_value = r_s11;
endmodule

FILE: rtl/gradient_noise_3d.sv
// Top level: 3D gradient noise, front hashing, queue, back interpolation.
//  channel | dir | payload
//  req     | in  | tdata[95:0] = coord_z,coord_y,coord_x (x lowest)
//  rsp     | out | tdata[23:0] = noise_value in [17:0]
// One word per cycle sustained while rsp_tready is high.
// Front and back stall independently; the two-entry queue absorbs the gap.
// Reset is synchronous and clears only valid state and queue pointers.
module gradient_noise_3d #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // coord_x, coord_y, coord_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // noise_value, zero pad
);
   import gn3_pkg::*;

   localparam int QW = 32 + 3*FRAC_BITS;
   logic fv, fr, bv, br;
   logic [31:0] fh;
   logic [3*FRAC_BITS-1:0] ff;
   logic [QW-1:0] qd;
   logic signed [OUT_W-1:0] nv;

   gn3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_x(req_tdata[31:0]), .in_y(req_tdata[63:32]), .in_z(req_tdata[95:64]),
      .out_valid(fv), .out_ready(fr), .out_hash(fh), .out_frac(ff));

   gn3_fifo #(.W(QW)) u_fifo (
      .clock, .reset, .in_valid(fv), .in_ready(fr), .in_data({ff, fh}),
      .out_valid(bv), .out_ready(br), .out_data(qd));

   gn3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .in_valid(bv), .in_ready(br),
      .in_hash(qd[31:0]), .in_frac(qd[QW-1:32]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_value(nv));

   assign rsp_tdata = {6'd0, nv};
endmodule

FILE: rtl/gn3_checker.sv
// Port checker for the noise block, bound to the top level.
`include "assert_macros.svh"
module gn3_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   `ASSERT_CLK(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")
   `ASSERT_CLK(a_pad, clock, reset, rsp_tvalid |-> rsp_tdata[23:18] == 6'd0, "pad nonzero")
   `ASSERT_CLK_NR(a_rst, clock, reset |=> !rsp_tvalid, "valid after reset")
   `ASSERT_CLK(a_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "data moved")
endmodule

bind gradient_noise_3d gn3_checker u_chk (.*);

FILE: sim/testbench.sv
// Testbench for gradient_noise_3d: random and directed points checked against a fixed-point noise predictor.
`timescale 1ns / 100ps
module testbench;
   import gn3_pkg::*;

   localparam int FB = 16;
   localparam longint ONE = 64'sd1 << FB;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   gradient_noise_3d #(.FRAC_BITS(FB)) dut (.*);

   always #5 clock = ~clock;

   logic [95:0]      pending_points[$];
   logic signed [17:0] expected_noise[$];
   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   bit quiet = 0;          // no idling in the last part
   int hold_rsp = 0;       // long receiver hold-off, in cycles
   logic req_tready_q = 1'b0;
   bit pause_tx = 0;

   function automatic longint fshift(longint v);
      return v >>> FB;     // arithmetic shift is floor
   endfunction

   function automatic longint fade(longint f);
      longint p1, f2, f3;
      p1 = (10 * ONE * ONE + 6 * f * f - 15 * f * ONE) >>> FB;
      f2 = (f * f) >>> FB;
      f3 = (f2 * f) >>> FB;
      return (f3 * p1 + (ONE >>> 1)) >>> FB;
   endfunction

   function automatic longint blend(longint w, longint a, longint b);
      return a + fshift((b - a) * w + (ONE >>> 1));
   endfunction

   function automatic longint corner(logic [7:0] hash, longint x, longint y, longint z);
      logic [3:0] h;
      longint u, v;
      h = hash[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic logic signed [17:0] noise_at(logic [95:0] p);
      logic [31:0] rx, ry, rz;
      logic [7:0] cx, cy, cz, a, aa, ab, b, ba, bb;
      longint x, y, z, u, v, w, x1, y1, z1, n;
      rx = p[31:0]; ry = p[63:32]; rz = p[95:64];
      cx = rx[FB+:8]; cy = ry[FB+:8]; cz = rz[FB+:8];
      x = rx[FB-1:0]; y = ry[FB-1:0]; z = rz[FB-1:0];
      u = fade(x); v = fade(y); w = fade(z);
      a = perm(cx) + cy; aa = perm(a) + cz; ab = perm(a + 8'd1) + cz;
      b = perm(cx + 8'd1) + cy; ba = perm(b) + cz; bb = perm(b + 8'd1) + cz;
      x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
      n = blend(w,
         blend(v, blend(u, corner(perm(aa), x, y, z), corner(perm(ba), x1, y, z)),
                  blend(u, corner(perm(ab), x, y1, z), corner(perm(bb), x1, y1, z))),
         blend(v, blend(u, corner(perm(aa + 8'd1), x, y, z1),
                           corner(perm(ba + 8'd1), x1, y, z1)),
                  blend(u, corner(perm(ab + 8'd1), x, y1, z1),
                           corner(perm(bb + 8'd1), x1, y1, z1))));
      if (n > 131071) n = 131071;
      if (n < -131072) n = -131072;
      return n[17:0];
   endfunction

   // driver
   int gap_tx = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready_q) begin
         if (gap_tx > 0) begin
            gap_tx <= gap_tx - 1;
            req_tvalid <= 1'b0;
         end else if (pending_points.size() > 0 && !(pause_tx && expected_noise.size() > 0)) begin
            req_tdata <= pending_points.pop_front();
            req_tvalid <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) gap_tx <= $urandom_range(1, 7);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver ready
   int gap_rx = 0;
   always @(negedge clock) begin
      if (hold_rsp > 0) begin
         hold_rsp <= hold_rsp - 1;
         rsp_tready <= 1'b0;
      end else if (gap_rx > 0) begin
         gap_rx <= gap_rx - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) gap_rx <= $urandom_range(1, 7);
      end
   end

   // monitor
   always @(posedge clock) begin
      logic signed [17:0] exp_v;
      req_tready_q <= req_tready && req_tvalid;
      if (!reset && req_tvalid && req_tready) begin
         expected_noise.push_back(noise_at(req_tdata));
         words_in++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_out++;
         if (expected_noise.size() == 0) begin
            $error("noise_value: unexpected word, actual %0d", $signed(rsp_tdata[17:0]));
            errors++;
         end else begin
            exp_v = expected_noise.pop_front();
            if (rsp_tdata[17:0] !== exp_v) begin
               $error("noise_value: expected %0d actual %0d", exp_v, $signed(rsp_tdata[17:0]));
               errors++;
            end
            if (rsp_tdata[23:18] !== 6'd0) begin
               $error("pad: expected 0 actual %0h", rsp_tdata[23:18]);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return {{16{1'b0}}, 16'($urandom())};
         2: return {{16{1'b1}}, 16'($urandom())};
         3: return {8'($urandom()), 8'($urandom()), 16'hFFFF};
         4: return {16'($urandom()), 16'h0000};
         default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      endcase
   endfunction

   task automatic drain();
      while (pending_points.size() > 0 || expected_noise.size() > 0 || req_tvalid)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] edges[8];
      edges = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0000_FFFF, 32'h0001_0000, 32'h00FF_8000, 32'hFF00_0001};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++)
         pending_points.push_back({edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]});
      for (int i = 0; i < 8; i++)
         pending_points.push_back({edges[i], edges[i], edges[i]});
      pending_points.push_back({32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_0000});
      drain();
      // fill the block while the receiver holds off
      hold_rsp = 60;
      for (int i = 0; i < 40; i++)
         pending_points.push_back({rand_coord(), rand_coord(), rand_coord()});
      drain();
      for (int i = 0; i < 900; i++) begin
         pending_points.push_back({rand_coord(), rand_coord(), rand_coord()});
         if (i == 400) begin
            while (pending_points.size() > 0) @(posedge clock);
            pause_tx = 1;
            while (expected_noise.size() > 0 || req_tvalid) @(posedge clock);
            pause_tx = 0;
         end
         if (i == 750) begin
            while (pending_points.size() > 0) @(posedge clock);
            quiet = 1;
         end
      end
      drain();
      repeat (30) @(posedge clock);
      $display("Covered %0d points in, %0d words out: field extremes, negative cells,",
               words_in, words_out);
      $display("cell wrap, long receiver stalls and a full drain pause.");
      if (errors == 0 && expected_noise.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end
endmodule
